FILE: hw/rtl/olir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olir_pkg: shared definitions for the ordered list block
// Sizes, request and status codes, and the command and status groups that
// pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package olir_pkg;

    // list storage
    localparam int CAPACITY  = 256;
    localparam int WORD_BITS = 32;

    // fixed field widths at the ports
    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 9;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // internal widths derived from the capacity
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int POS_W  = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } olir_status_t;

    // sequencer to datapath
    typedef struct packed {
        logic load_req;   // latch a new request
        logic eval;       // register the request status
        logic ptr_top;    // pointer to last entry
        logic ptr_pos;    // pointer to request position
        logic ptr_dec;
        logic ptr_inc;
        logic wr_up;      // move entry at pointer one place up
        logic wr_dn;      // move entry at pointer one place down
        logic wr_put;     // write the new word at the position
        logic take;       // capture the removed word
        logic cnt_inc;
        logic cnt_dec;
        logic out_load;   // load the result register
    } olir_cmd_t;

    // datapath to sequencer
    typedef struct packed {
        logic ins_ok;     // append or insert will go ahead
        logic rem_ok;     // remove will go ahead
        logic at_end;     // insert position equals the count
        logic up_done;    // pointer has reached the position
        logic dn_more;    // an entry remains above the pointer
    } olir_sts_t;

endpackage

FILE: hw/rtl/olir_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olir_req_if / olir_rsp_if: request and result channels
// Valid/ready channels; an item moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface olir_req_if
    import olir_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] index;
    logic [ITEM_W-1:0]  item;

    modport source (output valid, output func, output index, output item, input ready);
    modport sink   (input valid, input func, input index, input item, output ready);
endinterface

interface olir_rsp_if
    import olir_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ITEM_W-1:0]   removed_item;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output status, output removed_item, output count,
                    input ready);
    modport sink   (input valid, input status, input removed_item, input count,
                    output ready);
endinterface

FILE: hw/rtl/ordered_list_insert_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_remove: fixed-capacity ordered list
// Append, insert at index and remove at index with shifting of later entries.
// ----------------------------------------------------------------------------
// The list holds up to CAPACITY words in a single dual-port RAM and handles
// one request at a time; each request gives exactly one result with the
// status and the new count. Entries are moved one per cycle through the RAM,
// reading one address while writing its neighbour. An insert shifts later
// entries up before writing the new word, a remove captures the word and
// shifts later entries down, and an append or a rejected request skips the
// shift. A new item is taken once the previous one has been placed in the
// output register, even while that result still waits to be taken.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove
    import olir_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    olir_req_if.sink   req,
    olir_rsp_if.source rsp
);

    olir_cmd_t cmd;
    olir_sts_t sts;

    // sequencer
    olir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // storage and result registers
    olir_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .req_func         (req.func),
        .req_index        (req.index),
        .req_item         (req.item),
        .rsp_status       (rsp.status),
        .rsp_removed_item (rsp.removed_item),
        .rsp_count        (rsp.count)
    );

endmodule

FILE: hw/rtl/olir_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olir_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module olir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hw/rtl/olir_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olir_dp: ordered list datapath
// Request registers, entry count, shift pointer, entry RAM and the result
// register, all driven by commands from the sequencer.
// ----------------------------------------------------------------------------
module olir_dp
    import olir_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  olir_cmd_t           cmd,
    output olir_sts_t           sts,
    input  logic [FUNC_W-1:0]   req_func,
    input  logic [INDEX_W-1:0]  req_index,
    input  logic [ITEM_W-1:0]   req_item,
    output logic [STATUS_W-1:0] rsp_status,
    output logic [ITEM_W-1:0]   rsp_removed_item,
    output logic [COUNT_W-1:0]  rsp_count
);

    logic [FUNC_W-1:0]    op_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [ADDR_W-1:0]    ptr_reg;
    logic [ADDR_W-1:0]    ptr_next;
    olir_status_t         status_reg;
    olir_status_t         status_next;
    logic [WORD_BITS-1:0] removed_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [ITEM_W-1:0]    out_removed_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORD_BITS-1:0] rd_data;
    logic [POS_W-1:0]     count_pos;
    logic [CNT_W-1:0]     ptr_plus;

    assign count_pos = POS_W'(count_reg);
    assign ptr_plus  = CNT_W'(ptr_reg) + CNT_W'(1);

    // request checks and shift progress
    always_comb
    begin
        sts.ins_ok  = 1'b0;
        sts.rem_ok  = 1'b0;
        sts.at_end  = (pos_reg == count_pos);
        sts.up_done = (POS_W'(ptr_reg) == pos_reg);
        sts.dn_more = (ptr_plus < count_reg);
        status_next = ST_OK;
        unique case (op_reg)
            FUNC_APPEND, FUNC_INSERT:
            begin
                if (pos_reg > count_pos)
                begin
                    status_next = ST_RANGE;
                end
                else if (count_reg >= CNT_W'(CAPACITY))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    sts.ins_ok = 1'b1;
                end
            end
            FUNC_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else if (pos_reg >= count_pos)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    sts.rem_ok = 1'b1;
                end
            end
            FUNC_NONE:
            begin
                status_next = ST_OK;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // pointer; its next value is the read address so data follows the pointer
    always_comb
    begin
        priority if (cmd.ptr_top)
        begin
            ptr_next = ADDR_W'(count_reg - CNT_W'(1));
        end
        else if (cmd.ptr_pos)
        begin
            ptr_next = ADDR_W'(pos_reg);
        end
        else if (cmd.ptr_dec)
        begin
            ptr_next = ptr_reg - ADDR_W'(1);
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_reg + ADDR_W'(1);
        end
        else
        begin
            ptr_next = ptr_reg;
        end
    end

    // write port selection
    always_comb
    begin
        wr_en = cmd.wr_up | cmd.wr_dn | cmd.wr_put;
        priority if (cmd.wr_put)
        begin
            wr_addr = ADDR_W'(pos_reg);
            wr_data = word_reg;
        end
        else if (cmd.wr_up)
        begin
            wr_addr = ptr_reg + ADDR_W'(1);
            wr_data = rd_data;
        end
        else
        begin
            wr_addr = ptr_reg - ADDR_W'(1);
            wr_data = rd_data;
        end
    end

    olir_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (ptr_next),
        .rd_data (rd_data)
    );

    // entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    // request, pointer and result payload
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.load_req)
        begin
            op_reg      <= req_func;
            pos_reg     <= (req_func == FUNC_APPEND) ? count_pos : POS_W'(req_index);
            word_reg    <= WORD_BITS'(req_item);
            removed_reg <= '0;
        end
        if (cmd.eval)
        begin
            status_reg <= status_next;
        end
        if (cmd.take)
        begin
            removed_reg <= rd_data;
        end
        if (cmd.out_load)
        begin
            out_status_reg  <= status_reg;
            out_removed_reg <= ITEM_W'(removed_reg);
            out_count_reg   <= COUNT_W'(count_reg);
        end
    end

    assign rsp_status       = out_status_reg;
    assign rsp_removed_item = out_removed_reg;
    assign rsp_count        = out_count_reg;

    // count never passes the capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // writes stay within the list plus one slot
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (CNT_W'(wr_addr) <= count_reg))
        else $error("entry write beyond the list");

    // only a successful request returns a word
    a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && removed_reg != '0) |-> (status_reg == ST_OK))
        else $error("removed word on a failed request");

endmodule

FILE: hw/rtl/olir_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olir_ctrl: ordered list sequencer
// Takes one request at a time, steps the datapath through the shift and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module olir_ctrl
    import olir_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output olir_cmd_t cmd,
    input  olir_sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_UP,
        S_PUT,
        S_TAKE,
        S_DOWN,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (sts.ins_ok)
                begin
                    if (sts.at_end)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        cmd.ptr_top = 1'b1;
                        state_next  = S_UP;
                    end
                end
                else if (sts.rem_ok)
                begin
                    cmd.ptr_pos = 1'b1;
                    state_next  = S_TAKE;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_UP:
            begin
                cmd.wr_up = 1'b1;
                if (sts.up_done)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    cmd.ptr_dec = 1'b1;
                end
            end
            S_PUT:
            begin
                cmd.wr_put  = 1'b1;
                cmd.cnt_inc = 1'b1;
                state_next  = S_RESP;
            end
            S_TAKE:
            begin
                cmd.take = 1'b1;
                if (sts.dn_more)
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_DOWN;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_RESP;
                end
            end
            S_DOWN:
            begin
                cmd.wr_dn = 1'b1;
                if (sts.dn_more)
                begin
                    cmd.ptr_inc = 1'b1;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // an accepted item is checked next
    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_EVAL))
        else $error("accepted item not evaluated");

    // a free result slot never stalls the last step
    a_resp_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && !out_valid_reg) |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("result not issued into free slot");

endmodule
